// ----- src/tlq_pkg.sv -----
// tlq_pkg: shared types and constants of the traffic light queue step block
`timescale 1ns / 1ps
package tlq_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEP_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBER_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MS      = 3'd4;

  // register reset values
  localparam logic [15:0] RST_TICK_MS    = 16'd100;
  localparam logic [23:0] RST_DEP_PERIOD = 24'd2000;
  localparam logic [23:0] RST_GREEN_MS   = 24'd30000;
  localparam logic [23:0] RST_AMBER_MS   = 24'd3000;
  localparam logic [23:0] RST_RED_MS     = 24'd30000;

  // depth of the command queue between front and back
  localparam int CMD_Q_DEPTH = 2;

  typedef enum logic [1:0] {
    LIGHT_GREEN = 2'd0,
    LIGHT_AMBER = 2'd1,
    LIGHT_RED   = 2'd2
  } light_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ENQ,
    BK_READ,
    BK_STEP
  } back_state_t;

  typedef struct packed {
    logic [15:0] tick_ms;
    logic [23:0] departure_period_ms;
    logic [23:0] green_ms;
    logic [23:0] amber_ms;
    logic [23:0] red_ms;
  } cfg_t;

  // one classified tick request
  typedef struct packed {
    logic [3:0] count;
    logic       no_cars;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  light;
    logic        departed;
    logic [31:0] wait_ms;
    logic [8:0]  queue_length;
    logic [3:0]  dropped;
  } result_t;

endpackage

// ----- src/tlq_front.sv -----
// tlq_front: accepts tick requests, limits the arrival count and classifies them
`timescale 1ns / 1ps
module tlq_front #(
  parameter int MAX_ARRIVALS = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [3:0]    arrivals,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output tlq_pkg::cmd_t cmd
);
  import tlq_pkg::*;

  localparam logic [7:0] MAX_A = 8'(MAX_ARRIVALS);

  logic [3:0] clamped;

  // saturate the arrival count
  always_comb begin
    if ({4'd0, arrivals} > MAX_A) begin
      clamped = MAX_A[3:0];
    end else begin
      clamped = arrivals;
    end
  end

  assign in_ready = !cmd_valid || cmd_ready;

  // request holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.count   <= clamped;
      cmd.no_cars <= (clamped == 4'd0);
    end
  end

endmodule

// ----- src/tlq_cmd_q.sv -----
// tlq_cmd_q: short queue of classified requests between front and back
`timescale 1ns / 1ps
module tlq_cmd_q (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tlq_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tlq_pkg::cmd_t pop_data
);
  import tlq_pkg::*;

  localparam int PW = $clog2(CMD_Q_DEPTH);

  cmd_t        entries [CMD_Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = (count != (PW+1)'(CMD_Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/tlq_back.sv -----
// tlq_back: car queue memory, enqueue sequencer, departure and light update
`timescale 1ns / 1ps
module tlq_back #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  tlq_pkg::cfg_t    cfg,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  tlq_pkg::cmd_t    cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output tlq_pkg::result_t result
);
  import tlq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  back_state_t state;
  back_state_t state_next;

  logic [31:0]   mem [QUEUE_DEPTH];
  logic [31:0]   rd_data;
  logic [3:0]    cnt;
  logic [3:0]    lost;
  logic [AW-1:0] head_ptr;
  logic [AW-1:0] tail_ptr;
  logic [OW-1:0] occupancy;
  light_t        phase;
  logic [31:0]   phase_timer;
  logic [31:0]   departure_timer;
  logic [31:0]   now_ms;

  logic          enq_do;
  logic          step_do;
  logic          full;
  logic          depart;
  logic          phase_clr;
  logic          dep_clr;
  light_t        phase_next;
  logic [OW-1:0] occ_after;
  logic [31:0]   occ_ext;
  logic [31:0]   wait_val;
  logic [31:0]   pt_base;
  logic [31:0]   dt_base;
  logic [32:0]   pt_sum;
  logic [32:0]   dt_sum;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.no_cars ? BK_READ : BK_ENQ;
        end
      end
      BK_ENQ: begin
        if (cnt == 4'd1) begin
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_STEP;
      BK_STEP: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    enq_do    = 1'b0;
    step_do   = 1'b0;
    case (state)
      BK_IDLE: cmd_ready = 1'b1;
      BK_ENQ:  enq_do    = 1'b1;
      BK_READ: ;
      BK_STEP: step_do   = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign full = (occupancy >= OW'(QUEUE_DEPTH));

  // departure and phase decision
  always_comb begin
    depart     = 1'b0;
    phase_clr  = 1'b0;
    dep_clr    = 1'b0;
    phase_next = phase;
    case (phase)
      LIGHT_GREEN: begin
        depart = (departure_timer >= {8'd0, cfg.departure_period_ms}) &&
                 (occupancy != '0);
        if (phase_timer > {8'd0, cfg.green_ms}) begin
          phase_next = LIGHT_AMBER;
          phase_clr  = 1'b1;
        end
      end
      LIGHT_AMBER: begin
        if (phase_timer > {8'd0, cfg.amber_ms}) begin
          phase_next = LIGHT_RED;
          phase_clr  = 1'b1;
        end
      end
      LIGHT_RED: begin
        if (phase_timer > {8'd0, cfg.red_ms}) begin
          phase_next = LIGHT_GREEN;
          phase_clr  = 1'b1;
          dep_clr    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // step datapath: wait, occupancy and saturating timers
  assign wait_val  = now_ms - rd_data;
  assign occ_after = occupancy - OW'(depart);
  assign occ_ext   = 32'(occ_after);
  assign pt_base   = phase_clr ? 32'd0 : phase_timer;
  assign dt_base   = (depart || dep_clr) ? 32'd0 : departure_timer;
  assign pt_sum    = {1'b0, pt_base} + {17'd0, cfg.tick_ms};
  assign dt_sum    = {1'b0, dt_base} + {17'd0, cfg.tick_ms};

  // control and timer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_IDLE;
      cnt             <= '0;
      lost            <= '0;
      head_ptr        <= '0;
      tail_ptr        <= '0;
      occupancy       <= '0;
      phase           <= LIGHT_RED;
      phase_timer     <= '0;
      departure_timer <= '0;
      now_ms          <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      // result valid: set by the update, cleared once taken
      if (step_do) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_ready && cmd_valid) begin
        cnt  <= cmd.count;
        lost <= '0;
      end
      // one car a cycle into the queue, counted as lost when it is full
      if (enq_do) begin
        cnt <= cnt - 1'b1;
        if (full) begin
          lost <= lost + 1'b1;
        end else begin
          tail_ptr  <= (tail_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : tail_ptr + 1'b1;
          occupancy <= occupancy + 1'b1;
        end
      end
      // tick update
      if (step_do) begin
        if (depart) begin
          head_ptr <= (head_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : head_ptr + 1'b1;
        end
        occupancy       <= occ_after;
        phase           <= phase_next;
        phase_timer     <= pt_sum[32] ? 32'hFFFF_FFFF : pt_sum[31:0];
        departure_timer <= dt_sum[32] ? 32'hFFFF_FFFF : dt_sum[31:0];
        now_ms          <= now_ms + {16'd0, cfg.tick_ms};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step_do) begin
      result.light        <= phase_next;
      result.departed     <= depart;
      result.wait_ms      <= depart ? wait_val : 32'd0;
      result.queue_length <= occ_ext[8:0];
      result.dropped      <= lost;
    end
  end

  // arrival stamp memory, registered read at the head
  always_ff @(posedge clk) begin
    if (enq_do && !full) begin
      mem[tail_ptr] <= now_ms;
    end
    rd_data <= mem[head_ptr];
  end

endmodule

// ----- src/traffic_light_queue_step_top.sv -----
// traffic_light_queue_step_top: traffic light with car queue, one request per tick
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, arrivals                     | in
//   out     | out_valid, out_ready, light, departed, wait_ms,  | out
//           | queue_length, dropped                            |
//   cfg     | cfg_wr_en, cfg_index, cfg_data                   | in
//
// In the back end a request passes through these steps in order: taking the request,
// writing each car into the stamp memory (n cars, n being the limited arrival count,
// at most 15), the head read and the update.
// The front end and a two-entry queue take further requests meanwhile.
// Reset is synchronous; the stamp memory is not cleared and needs no sweep.
// A held result stalls the update cycle until it is taken.
`timescale 1ns / 1ps
module traffic_light_queue_step_top #(
  parameter int QUEUE_DEPTH  = 256,
  parameter int MAX_ARRIVALS = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3:0]                     arrivals,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     light,
  output logic                           departed,
  output logic [31:0]                    wait_ms,
  output logic [8:0]                     queue_length,
  output logic [3:0]                     dropped,
  input  logic                           cfg_wr_en,
  input  logic [tlq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlq_pkg::*;

  cfg_t    cfg;
  cmd_t    f_cmd;
  cmd_t    q_cmd;
  logic    f_valid;
  logic    f_ready;
  logic    q_valid;
  logic    q_ready;
  result_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_ms             <= RST_TICK_MS;
      cfg.departure_period_ms <= RST_DEP_PERIOD;
      cfg.green_ms            <= RST_GREEN_MS;
      cfg.amber_ms            <= RST_AMBER_MS;
      cfg.red_ms              <= RST_RED_MS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TICK_MS:    cfg.tick_ms             <= cfg_data[15:0];
        CFG_DEP_PERIOD: cfg.departure_period_ms <= cfg_data;
        CFG_GREEN_MS:   cfg.green_ms            <= cfg_data;
        CFG_AMBER_MS:   cfg.amber_ms            <= cfg_data;
        CFG_RED_MS:     cfg.red_ms              <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end
  tlq_front #(
    .MAX_ARRIVALS(MAX_ARRIVALS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .arrivals  (arrivals),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // request queue
  tlq_cmd_q u_q (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // back end
  tlq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign light        = result.light;
  assign departed     = result.departed;
  assign wait_ms      = result.wait_ms;
  assign queue_length = result.queue_length;
  assign dropped      = result.dropped;

  // no wait is reported without a departure
  a_wait_only_on_depart: assert property (@(posedge clk) disable iff (rst)
    out_valid && !departed |-> wait_ms == 32'd0)
    else $error("wait reported without a departure");

  // a car can only leave on green, so the light after it is never red
  a_depart_not_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && departed |-> light != LIGHT_RED)
    else $error("departure with red light");

  // a new result is only loaded once the previous one has gone
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(wait_ms) && $stable(queue_length))
    else $error("held result overwritten");

endmodule

// ----- dv/tb_traffic_light_queue_step_top.sv -----
// tb_traffic_light_queue_step_top: self-checking testbench of the traffic light queue step block
`timescale 1ns / 1ps
module tb_traffic_light_queue_step_top;
  import tlq_pkg::*;

  localparam int LANE_DEPTH = 256;
  localparam int LANE_PTR_W = $clog2(LANE_DEPTH);
  localparam int RANDOM_TICKS = 800;
  localparam int RUN_LIMIT_NS = 3000000;
  localparam logic [23:0] SPAN_MAX = 24'hFF_FFFF;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // receiver behaviour for one stretch of cycles
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [3:0]            arrivals = 4'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            light;
  logic                  departed;
  logic [31:0]           wait_ms;
  logic [8:0]            queue_length;
  logic [3:0]            dropped;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted register contents
  logic [15:0] set_tick_ms;
  logic [23:0] set_depart_ms;
  logic [23:0] set_green_ms;
  logic [23:0] set_amber_ms;
  logic [23:0] set_red_ms;

  // predicted lane state
  logic [31:0]           lane_stamps [LANE_DEPTH];
  logic [LANE_PTR_W-1:0] lane_head;
  logic [LANE_PTR_W-1:0] lane_tail;
  logic [8:0]            lane_count;
  light_t                lane_light;
  logic [31:0]           lane_phase_ms;
  logic [31:0]           lane_depart_ms;
  logic [31:0]           lane_clock_ms;

  result_t    expected_ticks [$];
  result_t    oldest;
  logic [3:0] pending_arrivals [$];
  int         mismatches = 0;

  logic     in_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_span = 0;

  traffic_light_queue_step_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .arrivals     (arrivals),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .light        (light),
    .departed     (departed),
    .wait_ms      (wait_ms),
    .queue_length (queue_length),
    .dropped      (dropped),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // timers saturate instead of wrapping
  function automatic logic [31:0] add_clamped(logic [31:0] base, logic [15:0] step);
    logic [32:0] sum;
    sum = {1'b0, base} + {17'd0, step};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // one tick of the lane: enqueue, light and departure, then advance time
  function automatic result_t advance_tick(logic [3:0] cars);
    result_t r;
    int k;
    r = '0;
    for (k = 0; k < int'(cars); k++) begin
      if (lane_count >= LANE_DEPTH) begin
        r.dropped = r.dropped + 4'd1;
      end else begin
        lane_stamps[lane_tail] = lane_clock_ms;
        lane_tail = lane_tail + 1'b1;
        lane_count = lane_count + 9'd1;
      end
    end
    case (lane_light)
      LIGHT_GREEN: begin
        // an empty lane keeps its departure timer running
        if (lane_depart_ms >= set_depart_ms && lane_count != 0) begin
          r.departed = 1'b1;
          r.wait_ms = lane_clock_ms - lane_stamps[lane_head];
          lane_head = lane_head + 1'b1;
          lane_count = lane_count - 9'd1;
          lane_depart_ms = '0;
        end
        if (lane_phase_ms > set_green_ms) begin
          lane_light = LIGHT_AMBER;
          lane_phase_ms = '0;
        end
      end
      LIGHT_AMBER: begin
        if (lane_phase_ms > set_amber_ms) begin
          lane_light = LIGHT_RED;
          lane_phase_ms = '0;
        end
      end
      LIGHT_RED: begin
        if (lane_phase_ms > set_red_ms) begin
          lane_light = LIGHT_GREEN;
          lane_phase_ms = '0;
          lane_depart_ms = '0;
        end
      end
      default: ;
    endcase
    r.light = lane_light;
    r.queue_length = lane_count;
    lane_clock_ms = lane_clock_ms + {16'd0, set_tick_ms};
    lane_depart_ms = add_clamped(lane_depart_ms, set_tick_ms);
    lane_phase_ms = add_clamped(lane_phase_ms, set_tick_ms);
    return r;
  endfunction

  function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, seen);
    end
  endfunction

  // phase length as a number of ticks, now and then an extreme
  function automatic logic [23:0] pick_span(logic [15:0] tick, int most_ticks);
    logic [39:0] span;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SPAN_MAX;
      default: begin
        span = 40'(tick) * 40'($urandom_range(0, most_ticks));
        if (span > 40'(SPAN_MAX)) return SPAN_MAX;
        return span[23:0];
      end
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  // tick is written with junk in the unused upper bits
  task automatic load_setting(logic [15:0] tick, logic [23:0] depart, logic [23:0] green,
                              logic [23:0] amber, logic [23:0] red);
    write_reg(CFG_TICK_MS, {8'($urandom), tick});
    write_reg(CFG_DEP_PERIOD, depart);
    write_reg(CFG_GREEN_MS, green);
    write_reg(CFG_AMBER_MS, amber);
    write_reg(CFG_RED_MS, red);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // block is idle once every request is taken and every result is back
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_arrivals.size() != 0 || in_valid || expected_ticks.size() != 0);
  endtask

  // request driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_arrivals.size() != 0) begin
        in_valid <= 1'b1;
        arrivals <= pending_arrivals.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // result receiver: free-running, coin-toss and sparse stretches
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_span <= $urandom_range(8, 80);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_FREE: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // monitor: track register writes, predict on each request, check each result
  always @(posedge clk) begin
    if (rst) begin
      set_tick_ms = RST_TICK_MS;
      set_depart_ms = RST_DEP_PERIOD;
      set_green_ms = RST_GREEN_MS;
      set_amber_ms = RST_AMBER_MS;
      set_red_ms = RST_RED_MS;
      lane_head = '0;
      lane_tail = '0;
      lane_count = '0;
      lane_light = LIGHT_RED;
      lane_phase_ms = '0;
      lane_depart_ms = '0;
      lane_clock_ms = '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TICK_MS:    set_tick_ms = cfg_data[15:0];
          CFG_DEP_PERIOD: set_depart_ms = cfg_data;
          CFG_GREEN_MS:   set_green_ms = cfg_data;
          CFG_AMBER_MS:   set_amber_ms = cfg_data;
          CFG_RED_MS:     set_red_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_ticks.push_back(advance_tick(arrivals));
      end
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, light %0d queue %0d",
                   $time, light, queue_length);
        end else begin
          oldest = expected_ticks.pop_front();
          compare_field("light", 32'(oldest.light), 32'(light));
          compare_field("departed", 32'(oldest.departed), 32'(departed));
          compare_field("wait_ms", oldest.wait_ms, wait_ms);
          compare_field("queue_length", 32'(oldest.queue_length), 32'(queue_length));
          compare_field("dropped", 32'(oldest.dropped), 32'(dropped));
        end
      end
    end
  end

  // stimulus: reset, directed phases, then random settings with random traffic
  initial begin : stimulus
    logic [3:0]  opening [7];
    logic [15:0] tick;
    int          k;
    int          queued;
    int          phase_no;
    int          phase_len;
    int          heavy;
    opening = '{4'd0, 4'd0, 4'd0, 4'd1, 4'd15, 4'd8, 4'd2};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // writes past the last register must change nothing
    for (k = int'(CFG_RED_MS) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end

    // zero-length phases: red and amber last two ticks, departures every tick,
    // an empty lane on green and a car leaving in the tick it came
    load_setting(16'd1000, 24'd0, 24'd2000, 24'd0, 24'd0);
    @(posedge clk);
    foreach (opening[k]) pending_arrivals.push_back(opening[k]);
    wait_idle();

    // frozen time: the lane fills up and later cars are dropped
    load_setting(16'd0, SPAN_MAX, SPAN_MAX, SPAN_MAX, SPAN_MAX);
    @(posedge clk);
    for (k = 0; k < 17; k++) pending_arrivals.push_back(4'd15);
    pending_arrivals.push_back(4'd0);

    queued = 0;
    phase_no = 0;
    while (queued < RANDOM_TICKS) begin
      wait_idle();
      case (phase_no)
        0: tick = TICK_MAX;
        1: tick = 16'd1;
        default: tick = 16'($urandom_range(1, TICK_MAX));
      endcase
      load_setting(tick, pick_span(tick, 2), pick_span(tick, 12),
                   pick_span(tick, 6), pick_span(tick, 12));
      @(posedge clk);
      // light traffic drains the lane, heavy traffic fills it
      heavy = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 5) : 0;
      phase_len = $urandom_range(30, 120);
      for (k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 9) < heavy) pending_arrivals.push_back(4'($urandom_range(0, 15)));
        else pending_arrivals.push_back(4'($urandom_range(0, 1)));
      end
      queued += phase_len;
      phase_no++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
